/* rtl/cftg_pkg.sv */
// Shared types and constants for the camera frame to gray texture core.
// Holds register codes, view modes, reset values and the per-stage item record.
// No dependencies.
package cftg_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_VIEW_MODE    = 3'd0,
        REG_FRAME_WIDTH  = 3'd1,
        REG_FRAME_HEIGHT = 3'd2,
        REG_ROW_PITCH    = 3'd3,
        REG_SIGMA_MASK   = 3'd4,
        REG_MAX_VALID    = 3'd5,
        REG_DEPTH_MIN    = 3'd6,
        REG_DEPTH_MAX    = 3'd7
    } cfg_index_t;

    // View modes
    typedef enum logic [1:0] {
        MODE_GRAY   = 2'd0,
        MODE_MIRROR = 2'd1,
        MODE_FLIP   = 2'd2,
        MODE_DEPTH  = 2'd3
    } view_mode_t;

    localparam int CFG_DATA_W = 16;
    localparam int ADDR_W     = 22;
    localparam int QUOT_W     = 8;

    // Reset values of the configuration registers
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [12:0] RST_ROW_PITCH    = 13'd640;
    localparam logic [7:0]  RST_SIGMA_MASK   = 8'h80;
    localparam logic [15:0] RST_MAX_VALID    = 16'd0;
    localparam logic [15:0] RST_DEPTH_MIN    = 16'd0;
    localparam logic [15:0] RST_DEPTH_MAX    = 16'd4000;

    // Current configuration as seen by the datapath
    typedef struct packed {
        view_mode_t  view_mode;
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [12:0] row_pitch_words;
        logic [7:0]  sigma_mask;
        logic [15:0] max_valid;
        logic [15:0] depth_min;
        logic [15:0] depth_max;
    } cfg_t;

    // One item as it moves down the divider chain
    typedef struct packed {
        logic              valid;
        logic              use_div;      // gray comes from the quotient
        logic [7:0]        gray;         // gray byte when no division applies
        logic [15:0]       rem;          // partial remainder
        logic [15:0]       divisor;      // depth_max - depth_min
        logic [QUOT_W-1:0] nq;           // numerator bits out, quotient bits in
        logic [ADDR_W-1:0] word_address;
        logic              frame_end;
    } cell_t;

endpackage

/* rtl/cftg_front.sv */
// Input stage: raster counters, texture address, depth invalidation and windowing setup.
// Depends on cftg_pkg. Feeds the first divider cell.
module cftg_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            pix_valid,
    input  logic [15:0]     sample,
    input  logic [7:0]      confidence,
    input  cftg_pkg::cfg_t  cfg,
    output cftg_pkg::cell_t cell_out
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SWW  = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int SWH  = (RW + 1 > 11) ? RW + 1 : 11;
    localparam int PW   = 13 + RW;
    localparam int SUMW = ((PW > CW) ? PW : CW) + 1;
    localparam int EXTW = (SUMW > cftg_pkg::ADDR_W) ? SUMW : cftg_pkg::ADDR_W;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    cftg_pkg::cell_t cell_reg;
    logic            valid_reg;

    logic [SWW-1:0] fw, w, wm1;
    logic [SWH-1:0] fh, h, hm1;
    logic           last_col, last_row;
    logic [CW-1:0]  col_sel;
    logic [RW-1:0]  row_sel;
    logic [PW-1:0]  prod;
    logic [SUMW-1:0] sum;
    logic [EXTW-1:0] sum_ext;
    logic           accept;

    logic [15:0] v0, v1, diff;
    logic        at_lo, at_hi;
    logic [23:0] numer;

    assign accept = pix_valid && advance;

    // Clamp frame size to 1..MAX
    always_comb
    begin
        fw = SWW'(cfg.frame_width);
        fh = SWH'(cfg.frame_height);
        if (fw == '0)
            w = SWW'(1);
        else if (fw > SWW'(MAX_WIDTH))
            w = SWW'(MAX_WIDTH);
        else
            w = fw;
        if (fh == '0)
            h = SWH'(1);
        else if (fh > SWH'(MAX_HEIGHT))
            h = SWH'(MAX_HEIGHT);
        else
            h = fh;
        wm1 = w - SWW'(1);
        hm1 = h - SWH'(1);
        last_col = SWW'(col_reg) >= wm1;
        last_row = SWH'(row_reg) >= hm1;
    end

    // Mirrored or flipped position, saturating at zero past the end
    always_comb
    begin
        col_sel = col_reg;
        row_sel = row_reg;
        if (cfg.view_mode == cftg_pkg::MODE_MIRROR)
            col_sel = last_col ? '0 : CW'(wm1 - SWW'(col_reg));
        else if (cfg.view_mode == cftg_pkg::MODE_FLIP)
            row_sel = last_row ? '0 : RW'(hm1 - SWH'(row_reg));
    end

    // Texture word address, modulo the address width
    always_comb
    begin
        prod    = PW'(cfg.row_pitch_words) * PW'(row_sel);
        sum     = SUMW'(prod) + SUMW'(col_sel);
        sum_ext = EXTW'(sum);
    end

    // Depth invalidation and window setup
    always_comb
    begin
        v0 = ((confidence & cfg.sigma_mask) != 8'd0) ? 16'd0 : sample;
        v1 = ((cfg.max_valid != 16'd0) && (v0 > cfg.max_valid)) ? 16'd0 : v0;
        at_lo = v1 <= cfg.depth_min;
        at_hi = v1 >= cfg.depth_max;
        diff  = v1 - cfg.depth_min;
        // diff * 255
        numer = {diff, 8'd0} - {8'd0, diff};
    end

    // Raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance)
                valid_reg <= pix_valid;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg.valid        <= 1'b1;
            cell_reg.use_div      <= (cfg.view_mode == cftg_pkg::MODE_DEPTH) && !at_lo && !at_hi;
            cell_reg.gray         <= (cfg.view_mode != cftg_pkg::MODE_DEPTH) ? sample[7:0] :
                                     (at_lo ? 8'd0 : 8'd255);
            cell_reg.rem          <= numer[23:8];
            cell_reg.nq           <= numer[7:0];
            cell_reg.divisor      <= cfg.depth_max - cfg.depth_min;
            cell_reg.word_address <= sum_ext[cftg_pkg::ADDR_W-1:0];
            cell_reg.frame_end    <= last_col && last_row;
        end
    end

    always_comb
    begin
        cell_out       = cell_reg;
        cell_out.valid = valid_reg;
    end

endmodule

/* rtl/cftg_div_cell.sv */
// One restoring-division cell: resolves one quotient bit and passes the item on.
// Depends on cftg_pkg. Chained eight deep in the top level.
module cftg_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  cftg_pkg::cell_t cell_in,
    output cftg_pkg::cell_t cell_out
);

    cftg_pkg::cell_t cell_reg, cell_next;
    logic            valid_reg;
    logic [16:0]     r2;
    logic            ge;

    // Shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        r2        = {cell_in.rem, cell_in.nq[cftg_pkg::QUOT_W-1]};
        ge        = r2 >= {1'b0, cell_in.divisor};
        cell_next = cell_in;
        cell_next.rem = ge ? 16'(r2 - {1'b0, cell_in.divisor}) : r2[15:0];
        cell_next.nq  = {cell_in.nq[cftg_pkg::QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= cell_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            cell_reg <= cell_next;
    end

    always_comb
    begin
        cell_out       = cell_reg;
        cell_out.valid = valid_reg;
    end

endmodule

/* rtl/camera_frame_to_gray_texture_core.sv */
// Top level of the camera frame to gray texture core.
// Depends on cftg_pkg, cftg_front and cftg_div_cell.
//
// Usage:
//   Pixels enter in raster order on the pix channel (pix_valid/pix_stall,
//   sample, confidence). Each pixel gives exactly one result on the res
//   channel (res_valid/res_stall): the texture word address, the gray byte
//   copied into three channels, and a flag on the last pixel of the frame.
//   A result is offered once its pixel has been accepted and has passed
//   ten registers: the input stage, eight division cells (one quotient bit
//   each for the depth window) and the output register.
//   Throughput is one pixel per cycle while the receiver takes results.
//   When the receiver stalls a waiting result, the whole cell chain holds
//   and pix_stall is raised in the same cycle; nothing is dropped.
//   Configuration is written through cfg_write/cfg_index/cfg_data while no
//   pixel is in flight. Reset clears the raster counters and the chain and
//   loads the default configuration (640x480, depth window 0..4000).
module camera_frame_to_gray_texture_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // pixel channel
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic [15:0] sample,
    input  logic [7:0]  confidence,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [21:0] word_address,
    output logic [23:0] pixel_word,
    output logic        frame_end
);

    localparam int NCELL = cftg_pkg::QUOT_W;

    cftg_pkg::cfg_t  cfg_reg;
    cftg_pkg::cell_t chain [0:NCELL];
    logic            advance;
    logic            res_valid_reg;
    logic [21:0]     word_address_reg;
    logic [7:0]      gray_reg;
    logic            frame_end_reg;

    assign advance   = !res_valid_reg || !res_stall;
    assign pix_stall = !advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_mode       <= cftg_pkg::MODE_GRAY;
            cfg_reg.frame_width     <= cftg_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height    <= cftg_pkg::RST_FRAME_HEIGHT;
            cfg_reg.row_pitch_words <= cftg_pkg::RST_ROW_PITCH;
            cfg_reg.sigma_mask      <= cftg_pkg::RST_SIGMA_MASK;
            cfg_reg.max_valid       <= cftg_pkg::RST_MAX_VALID;
            cfg_reg.depth_min       <= cftg_pkg::RST_DEPTH_MIN;
            cfg_reg.depth_max       <= cftg_pkg::RST_DEPTH_MAX;
        end
        else if (cfg_write)
        begin
            unique case (cftg_pkg::cfg_index_t'(cfg_index))
                cftg_pkg::REG_VIEW_MODE:
                    cfg_reg.view_mode <= cftg_pkg::view_mode_t'(cfg_data[1:0]);
                cftg_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width     <= cfg_data[10:0];
                cftg_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height    <= cfg_data[10:0];
                cftg_pkg::REG_ROW_PITCH:    cfg_reg.row_pitch_words <= cfg_data[12:0];
                cftg_pkg::REG_SIGMA_MASK:   cfg_reg.sigma_mask      <= cfg_data[7:0];
                cftg_pkg::REG_MAX_VALID:    cfg_reg.max_valid       <= cfg_data;
                cftg_pkg::REG_DEPTH_MIN:    cfg_reg.depth_min       <= cfg_data;
                cftg_pkg::REG_DEPTH_MAX:    cfg_reg.depth_max       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage
    cftg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .pix_valid  (pix_valid),
        .sample     (sample),
        .confidence (confidence),
        .cfg        (cfg_reg),
        .cell_out   (chain[0])
    );

    // Division chain, one quotient bit per cell
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        cftg_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= chain[NCELL].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_address_reg <= chain[NCELL].word_address;
            gray_reg         <= chain[NCELL].use_div ? chain[NCELL].nq : chain[NCELL].gray;
            frame_end_reg    <= chain[NCELL].frame_end;
        end
    end

    assign res_valid    = res_valid_reg;
    assign word_address = word_address_reg;
    assign pixel_word   = {gray_reg, gray_reg, gray_reg};
    assign frame_end    = frame_end_reg;

endmodule

/* verif/gray_texel_checker.sv */
`timescale 1ns / 100ps
// Result checker for camera_frame_to_gray_texture_core: watches the config port and both
// channels, predicts each texel from its own copy of registers and raster counters.
// Depends on cftg_pkg.
module gray_texel_checker
    import cftg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        pix_valid,
    input  logic        pix_stall,
    input  logic [15:0] sample,
    input  logic [7:0]  confidence,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [21:0] word_address,
    input  logic [23:0] pixel_word,
    input  logic        frame_end,
    output int          results_seen,
    output int          mismatches,
    output int          frames_seen
);

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    typedef struct packed {
        logic [21:0] addr;
        logic [23:0] word;
        logic        fend;
    } texel_t;

    // shadow of the configuration registers
    view_mode_t  mode;
    logic [10:0] frame_w;
    logic [10:0] frame_h;
    logic [12:0] pitch;
    logic [7:0]  sig_mask;
    logic [15:0] max_ok;
    logic [15:0] win_lo;
    logic [15:0] win_hi;

    // raster position of the next pixel
    logic [9:0] col_pos;
    logic [9:0] row_pos;

    texel_t texel_due[$];
    int n_res    = 0;
    int n_fail   = 0;
    int n_frames = 0;

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        n_fail++;
    endtask

    // depth sample -> gray byte, with invalidation and window
    function automatic logic [7:0] window_depth(input logic [15:0] s, input logic [7:0] c);
        int unsigned v;
        v = s;
        if (sig_mask != 0 && (c & sig_mask) != 0)
            v = 0;
        if (max_ok != 0 && v > max_ok)
            v = 0;
        if (v <= win_lo)
            return 8'd0;
        if (v >= win_hi)
            return 8'd255;
        return ((v - win_lo) * 255) / (win_hi - win_lo);
    endfunction

    // expected texel for one pixel; advances the raster counters
    function automatic texel_t predict_texel(input logic [15:0] s, input logic [7:0] c);
        texel_t      t;
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned addr;
        logic [7:0]  g;
        logic        last_c;
        logic        last_r;
        w = (frame_w == 0) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
        h = (frame_h == 0) ? 1 : ((frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h);
        last_c = (col_pos >= w - 1);
        last_r = (row_pos >= h - 1);
        col = col_pos;
        row = row_pos;
        g = (mode == MODE_DEPTH) ? window_depth(s, c) : s[7:0];
        // mirrored or flipped index saturates at 0 past the last position
        if (mode == MODE_MIRROR)
            col = last_c ? 0 : w - 1 - col_pos;
        else if (mode == MODE_FLIP)
            row = last_r ? 0 : h - 1 - row_pos;
        addr = pitch * row + col;
        t.addr = addr[21:0];
        t.word = {g, g, g};
        t.fend = last_c && last_r;
        if (last_c)
        begin
            col_pos = '0;
            row_pos = last_r ? '0 : row_pos + 10'd1;
        end
        else
        begin
            col_pos = col_pos + 10'd1;
        end
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        texel_t want;
        texel_t next_texel;
        if (!rst_n)
        begin
            mode     = MODE_GRAY;
            frame_w  = RST_FRAME_WIDTH;
            frame_h  = RST_FRAME_HEIGHT;
            pitch    = RST_ROW_PITCH;
            sig_mask = RST_SIGMA_MASK;
            max_ok   = RST_MAX_VALID;
            win_lo   = RST_DEPTH_MIN;
            win_hi   = RST_DEPTH_MAX;
            col_pos  = '0;
            row_pos  = '0;
            texel_due.delete();
        end
        else
        begin
            // compare the returned texel with the oldest prediction
            if (res_valid && !res_stall)
            begin
                if (texel_due.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected texel addr=%0h word=%0h end=%0b",
                                            word_address, pixel_word, frame_end));
                end
                else
                begin
                    want = texel_due.pop_front();
                    if (word_address !== want.addr)
                        flag_mismatch($sformatf("texel %0d word_address %0h, want %0h",
                                                n_res, word_address, want.addr));
                    if (pixel_word !== want.word)
                        flag_mismatch($sformatf("texel %0d pixel_word %0h, want %0h",
                                                n_res, pixel_word, want.word));
                    if (frame_end !== want.fend)
                        flag_mismatch($sformatf("texel %0d frame_end %0b, want %0b",
                                                n_res, frame_end, want.fend));
                end
                n_res++;
                if (frame_end)
                    n_frames++;
            end
            if (pix_valid && !pix_stall)
            begin
                next_texel = predict_texel(sample, confidence);
                texel_due.insert(texel_due.size(), next_texel);
            end
            // mirror register writes
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_VIEW_MODE:    mode     = view_mode_t'(cfg_data[1:0]);
                    REG_FRAME_WIDTH:  frame_w  = cfg_data[10:0];
                    REG_FRAME_HEIGHT: frame_h  = cfg_data[10:0];
                    REG_ROW_PITCH:    pitch    = cfg_data[12:0];
                    REG_SIGMA_MASK:   sig_mask = cfg_data[7:0];
                    REG_MAX_VALID:    max_ok   = cfg_data;
                    REG_DEPTH_MIN:    win_lo   = cfg_data;
                    REG_DEPTH_MAX:    win_hi   = cfg_data;
                    default:          ;
                endcase
            end
        end
        results_seen <= n_res;
        mismatches   <= n_fail;
        frames_seen  <= n_frames;
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Top testbench for camera_frame_to_gray_texture_core: clock, reset, register writes,
// pixel stimulus, result stalls and the verdict. Depends on cftg_pkg, the core and gray_texel_checker.
module tb_top;
    import cftg_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_SETTINGS = 10;
    localparam int PIXELS_PER_SET  = 33;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_write  = 1'b0;
    logic [2:0]  cfg_index  = '0;
    logic [15:0] cfg_data   = '0;
    logic        pix_valid  = 1'b0;
    logic        pix_stall;
    logic [15:0] sample     = '0;
    logic [7:0]  confidence = '0;
    logic        res_valid;
    logic        res_stall  = 1'b0;
    logic [21:0] word_address;
    logic [23:0] pixel_word;
    logic        frame_end;

    int results_seen;
    int mismatches;
    int frames_seen;
    int pixels_sent   = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    bit tx_idle       = 1'b0;
    bit rx_idle       = 1'b0;
    bit hold_results  = 1'b0;

    // current window, used to aim depth samples
    view_mode_t  cur_mode = MODE_GRAY;
    logic [15:0] cur_lo   = '0;
    logic [15:0] cur_hi   = '0;
    logic [15:0] cur_mv   = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    camera_frame_to_gray_texture_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .sample       (sample),
        .confidence   (confidence),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .word_address (word_address),
        .pixel_word   (pixel_word),
        .frame_end    (frame_end)
    );

    gray_texel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .sample       (sample),
        .confidence   (confidence),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .word_address (word_address),
        .pixel_word   (pixel_word),
        .frame_end    (frame_end),
        .results_seen (results_seen),
        .mismatches   (mismatches),
        .frames_seen  (frames_seen)
    );

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // write all eight registers; block must be idle
    task automatic apply_setting(input view_mode_t m, input logic [10:0] w,
                                 input logic [10:0] h, input logic [12:0] p,
                                 input logic [7:0] msk, input logic [15:0] mv,
                                 input logic [15:0] lo, input logic [15:0] hi);
        write_reg(REG_VIEW_MODE, 16'(m));
        write_reg(REG_FRAME_WIDTH, 16'(w));
        write_reg(REG_FRAME_HEIGHT, 16'(h));
        write_reg(REG_ROW_PITCH, 16'(p));
        write_reg(REG_SIGMA_MASK, 16'(msk));
        write_reg(REG_MAX_VALID, mv);
        write_reg(REG_DEPTH_MIN, lo);
        write_reg(REG_DEPTH_MAX, hi);
        cfg_write <= 1'b0;
        cur_mode = m;
        cur_lo   = lo;
        cur_hi   = hi;
        cur_mv   = mv;
        settings_used++;
    endtask

    // offer one pixel and hold it until accepted
    task automatic send_pixel(input logic [15:0] s, input logic [7:0] c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid  <= 1'b1;
        sample     <= s;
        confidence <= c;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        pixels_sent++;
    endtask

    // sender pauses until every texel is back, then lets the pipe settle
    task automatic drain();
        pix_valid <= 1'b0;
        while (results_seen < pixels_sent) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd1024;
            2:       return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [12:0] pick_pitch();
        case ($urandom_range(0, 5))
            0:       return 13'd0;
            1:       return 13'd8191;
            2:       return 13'($urandom);
            default: return 13'($urandom_range(1, 16));
        endcase
    endfunction

    // depth samples are aimed at the window edges and the validity limit
    function automatic logic [15:0] pick_sample();
        if (cur_mode != MODE_DEPTH)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(cur_lo, cur_hi));
            2:
            begin
                case ($urandom_range(0, 5))
                    0:       return cur_lo;
                    1:       return cur_lo + 16'd1;
                    2:       return cur_hi - 16'd1;
                    3:       return cur_hi;
                    4:       return cur_mv;
                    default: return cur_mv + 16'd1;
                endcase
            end
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [7:0] pick_confidence();
        return ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    endfunction

    task automatic random_setting();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [7:0]  msk;
        logic [15:0] mv;
        case ($urandom_range(0, 4))
            0:
            begin
                // inverted window
                lo = 16'($urandom);
                hi = 16'($urandom_range(0, lo));
            end
            1:
            begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            default:
            begin
                lo = 16'($urandom_range(0, 4000));
                hi = lo + 16'($urandom_range(1, 3000));
            end
        endcase
        case ($urandom_range(0, 3))
            0:       msk = 8'd0;
            1:       msk = 8'hFF;
            default: msk = 8'($urandom);
        endcase
        mv = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        apply_setting(view_mode_t'($urandom_range(0, 3)), pick_size(), pick_size(),
                      pick_pitch(), msk, mv, lo, hi);
    endtask

    task automatic random_pixels(input int n);
        repeat (n) send_pixel(pick_sample(), pick_confidence());
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int n;
        while (!rst_n) @(posedge clk);
        forever
        begin
            n = 0;
            if (hold_results)
                n = HOLD_CYCLES;
            else if (rx_idle)
                n = $urandom_range(0, 3);
            hold_results = 1'b0;
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one full 3x2 frame of field extremes in gray mode, then mirror and flip
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        apply_setting(MODE_GRAY, 11'd3, 11'd2, 13'd5, 8'h80, 16'd0, 16'd0, 16'd4000);
        send_pixel(16'h0000, 8'h00);
        send_pixel(16'hFFFF, 8'hFF);
        send_pixel(16'h00FF, 8'h00);
        send_pixel(16'hFF00, 8'hFF);
        send_pixel(16'h5AA5, 8'h5A);
        send_pixel(16'hA55A, 8'hA5);
        drain();
        apply_setting(MODE_MIRROR, 11'd3, 11'd2, 13'd5, 8'h80, 16'd0, 16'd0, 16'd4000);
        repeat (4) send_pixel(16'($urandom), 8'($urandom));
        drain();
        // flip with a smaller frame while counters sit mid-frame
        apply_setting(MODE_FLIP, 11'd2, 11'd1, 13'd7, 8'h80, 16'd0, 16'd0, 16'd4000);
        repeat (4) send_pixel(16'($urandom), 8'($urandom));
        drain();
        // depth: window edges, masked confidence, over the validity limit
        apply_setting(MODE_DEPTH, 11'd4, 11'd4, 13'd4, 8'h80, 16'd3000, 16'd100, 16'd1000);
        send_pixel(16'd0, 8'h00);
        send_pixel(16'd100, 8'h00);
        send_pixel(16'd101, 8'h00);
        send_pixel(16'd999, 8'h00);
        send_pixel(16'd1000, 8'h00);
        send_pixel(16'd500, 8'h80);
        send_pixel(16'd500, 8'h7F);
        send_pixel(16'd3001, 8'h00);
        drain();
        // inverted window, zero width, oversize height, zero pitch
        apply_setting(MODE_DEPTH, 11'd0, 11'd2047, 13'd0, 8'd0, 16'd0, 16'd2000, 16'd1000);
        send_pixel(16'd2000, 8'h00);
        send_pixel(16'd2001, 8'h00);
        send_pixel(16'hFFFF, 8'hFF);
        drain();

        // address wrap: tall single-column frame flipped with the widest pitch
        apply_setting(MODE_FLIP, 11'd1, 11'd1024, 13'd8191, 8'h00, 16'd0, 16'd0, 16'd1);
        random_pixels(30);
        drain();
        apply_setting(MODE_MIRROR, 11'd1024, 11'd1, 13'd4096, 8'hFF, 16'd0, 16'd0, 16'd1);
        random_pixels(30);
        drain();
        apply_setting(MODE_DEPTH, 11'd5, 11'd3, 13'd1, 8'h00, 16'hFFFF, 16'd0, 16'hFFFF);
        random_pixels(30);
        drain();

        // back-pressure: results held while pixels keep coming
        random_setting();
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_results = 1'b1;
        random_pixels(40);
        drain();

        repeat (RANDOM_SETTINGS)
        begin
            random_setting();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            random_pixels(PIXELS_PER_SET);
            drain();
        end

        $display("ran %0d pixels under %0d register settings in all four view modes",
                 pixels_sent, settings_used);
        $display("%0d texels checked, %0d frame ends, %0d mismatches",
                 results_seen, frames_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
